### hdl/shtfe_pkg.sv
// constants and types shared by the spi hub transfer frame engine
package shtfe_pkg;

    localparam int DUMMY_SLOTS   = 48;
    localparam int MAX_WRITE_LEN = 32;
    localparam int MAX_READ_LEN  = 128;
    localparam int REG_READ_LEN  = 32;
    localparam int STORE_DEPTH   = MAX_WRITE_LEN;
    localparam int STORE_AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COUNT_W       = $clog2(STORE_DEPTH + 1);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LOAD  = 2'd0;
    localparam t_cmd CMD_START = 2'd1;
    localparam t_cmd CMD_SLOT  = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_BAD_LEN = 2'd1;
    localparam t_status ST_NO_ACK  = 2'd2;
    localparam t_status ST_CSUM    = 2'd3;

    localparam logic [7:0] CSUM_SEED   = 8'hFF;
    localparam logic [7:0] REG_PROTO_RD = 8'h55;
    localparam logic [7:0] REG_PROTO_WR = 8'hAA;
    localparam logic [7:0] REG_ACK1     = 8'h5A;
    localparam logic [7:0] REG_ACK2     = 8'hA5;
    localparam logic [7:0] DL_PROTO_RD  = 8'h33;
    localparam logic [7:0] DL_PROTO_WR  = 8'hCC;
    localparam logic [7:0] DL_ACK1      = 8'h3C;
    localparam logic [7:0] DL_ACK2      = 8'hC3;

    // header slots before the payload
    localparam int HDR_SLOTS = 4;

endpackage

### hdl/shtfe_if.sv
// request and result channel interfaces of the spi hub transfer frame engine
interface shtfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       is_write;
    logic [7:0] addr_byte;
    logic [7:0] length;
    logic [7:0] payload_byte;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, is_write, addr_byte, length, payload_byte, rx_byte,
                    input ready);
    modport sink   (input valid, cmd, is_write, addr_byte, length, payload_byte, rx_byte,
                    output ready);
endinterface

interface shtfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
    logic       busy_res;

    modport source (output valid, tx_byte, read_valid, read_byte, done_res, status, busy_res,
                    input ready);
    modport sink   (input valid, tx_byte, read_valid, read_byte, done_res, status, busy_res,
                    output ready);
endinterface

### hdl/spi_hub_transfer_frame_engine_core.sv
// spi hub transfer frame engine: framer, ack scan and reply capture around a payload ram
//
// channel   dir  handshake       contents
// i_in      in   valid/ready     cmd, is_write, addr_byte, length, payload_byte, rx_byte
// o_out     out  valid/ready     tx_byte, read_valid, read_byte, done_res, status, busy_res
// cfg       in   i_cfg_we        i_cfg_wdata = download_mode
//
// one request per cycle while i_in.ready is high, one result per request, held in the result register
// the payload ram is read every cycle at the entry of the next slot, so data is ready
// when the slot request arrives
// i_in.ready is high when the result register is empty or taken in the same cycle
// reset is synchronous; the payload ram is not cleared, payload slots past the fill count send 0
module spi_hub_transfer_frame_engine_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    shtfe_in_if.sink          i_in,
    shtfe_out_if.source       o_out
);

    localparam int COUNT_W = shtfe_pkg::COUNT_W;

    logic                                 r_dl;
    logic [shtfe_pkg::COUNT_W-1:0]        r_payload_count, n_payload_count;
    logic [7:0]                           r_slot, n_slot;
    logic                                 r_active, n_active;
    logic                                 r_write_dir, n_write_dir;
    logic [7:0]                           r_addr, n_addr;
    logic [7:0]                           r_len, n_len;
    logic [7:0]                           r_tx_csum, n_tx_csum;
    logic [7:0]                           r_prev_rx, n_prev_rx;
    logic                                 r_ack_seen, n_ack_seen;
    logic [7:0]                           r_cap_cnt, n_cap_cnt;
    logic [7:0]                           r_rx_csum, n_rx_csum;
    logic                                 r_csum_ok, n_csum_ok;
    logic                                 r_checked, n_checked;

    logic [7:0]                           r_store [shtfe_pkg::STORE_DEPTH];
    logic [7:0]                           r_rd_data;
    logic [shtfe_pkg::STORE_AW-1:0]       rd_addr;
    logic [7:0]                           rd_off;

    logic                                 r_out_valid;
    logic [7:0]                           r_tx, n_tx;
    logic                                 r_rvalid, n_rvalid;
    logic [7:0]                           r_rbyte, n_rbyte;
    logic                                 r_done, n_done;
    logic [1:0]                           r_status, n_status;
    logic                                 r_busy;

    logic                                 accept;
    logic                                 store_we;
    logic [7:0]                           proto_rd, proto_wr, ack1, ack2;
    logic [8:0]                           limit;
    logic [8:0]                           total;
    logic [8:0]                           wr_end;
    logic [7:0]                           k_off;
    logic                                 ack_now;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign proto_rd = r_dl ? shtfe_pkg::DL_PROTO_RD : shtfe_pkg::REG_PROTO_RD;
    assign proto_wr = r_dl ? shtfe_pkg::DL_PROTO_WR : shtfe_pkg::REG_PROTO_WR;
    assign ack1     = r_dl ? shtfe_pkg::DL_ACK1 : shtfe_pkg::REG_ACK1;
    assign ack2     = r_dl ? shtfe_pkg::DL_ACK2 : shtfe_pkg::REG_ACK2;

    assign limit  = i_in.is_write ? 9'(shtfe_pkg::MAX_WRITE_LEN)
                  : (r_dl ? 9'(shtfe_pkg::MAX_READ_LEN) : 9'(shtfe_pkg::REG_READ_LEN));
    assign total  = {1'b0, r_len} + 9'(shtfe_pkg::DUMMY_SLOTS);
    assign wr_end = {1'b0, r_len} + 9'(shtfe_pkg::HDR_SLOTS);
    assign k_off  = r_slot - 8'(shtfe_pkg::HDR_SLOTS);

    assign store_we = accept && (i_in.cmd == shtfe_pkg::CMD_LOAD) && !r_active
                   && (r_payload_count < COUNT_W'(shtfe_pkg::STORE_DEPTH));

    // entry of the slot that comes next
    assign rd_off  = n_slot - 8'(shtfe_pkg::HDR_SLOTS);
    assign rd_addr = rd_off[shtfe_pkg::STORE_AW-1:0];

    always_comb begin
        n_payload_count = r_payload_count;
        n_slot          = r_slot;
        n_active        = r_active;
        n_write_dir     = r_write_dir;
        n_addr          = r_addr;
        n_len           = r_len;
        n_tx_csum       = r_tx_csum;
        n_prev_rx       = r_prev_rx;
        n_ack_seen      = r_ack_seen;
        n_cap_cnt       = r_cap_cnt;
        n_rx_csum       = r_rx_csum;
        n_csum_ok       = r_csum_ok;
        n_checked       = r_checked;
        n_tx            = 8'h00;
        n_rvalid        = 1'b0;
        n_rbyte         = 8'h00;
        n_done          = 1'b0;
        n_status        = shtfe_pkg::ST_OK;
        ack_now         = 1'b0;
        if (accept) begin
            unique case (i_in.cmd)
                shtfe_pkg::CMD_LOAD: begin
                    if (store_we) begin
                        n_payload_count = r_payload_count + COUNT_W'(1);
                    end
                end
                shtfe_pkg::CMD_START: begin
                    if (!r_active) begin
                        n_payload_count = '0;
                        if ({1'b0, i_in.length} > limit) begin
                            n_done   = 1'b1;
                            n_status = shtfe_pkg::ST_BAD_LEN;
                        end else begin
                            n_active    = 1'b1;
                            n_write_dir = i_in.is_write;
                            n_addr      = i_in.addr_byte;
                            n_len       = i_in.length;
                            n_slot      = 8'h00;
                            n_tx_csum   = shtfe_pkg::CSUM_SEED;
                            n_prev_rx   = 8'h00;
                            n_ack_seen  = 1'b0;
                            n_cap_cnt   = 8'h00;
                            n_rx_csum   = shtfe_pkg::CSUM_SEED;
                            n_csum_ok   = 1'b0;
                            n_checked   = 1'b0;
                        end
                    end
                end
                shtfe_pkg::CMD_SLOT: begin
                    if (r_active) begin
                        // drive
                        if (r_slot == 8'd0) begin
                            n_tx      = r_write_dir ? proto_wr : proto_rd;
                            n_tx_csum = r_tx_csum ^ n_tx;
                        end else if (r_slot == 8'd1) begin
                            n_tx      = r_addr;
                            n_tx_csum = r_tx_csum ^ n_tx;
                        end else if (r_slot == 8'd2) begin
                            n_tx      = r_len;
                            n_tx_csum = r_tx_csum ^ n_tx;
                        end else if (r_slot == 8'd3) begin
                            n_tx      = r_tx_csum;
                            n_tx_csum = shtfe_pkg::CSUM_SEED;
                        end else if (r_write_dir && ({1'b0, r_slot} < wr_end)) begin
                            n_tx      = (k_off < 8'(r_payload_count)) ? r_rd_data : 8'h00;
                            n_tx_csum = r_tx_csum ^ n_tx;
                        end else if (r_write_dir && ({1'b0, r_slot} == wr_end)) begin
                            n_tx = r_tx_csum;
                        end
                        // receive
                        if (!r_write_dir && r_ack_seen) begin
                            if (r_cap_cnt < r_len) begin
                                n_rvalid  = 1'b1;
                                n_rbyte   = i_in.rx_byte;
                                n_rx_csum = r_rx_csum ^ i_in.rx_byte;
                                n_cap_cnt = r_cap_cnt + 8'd1;
                            end else if (!r_checked) begin
                                n_checked = 1'b1;
                                n_csum_ok = (i_in.rx_byte == r_rx_csum);
                            end
                        end
                        ack_now = (r_slot >= (r_write_dir ? 8'd1 : 8'd5))
                               && (r_prev_rx == ack1) && (i_in.rx_byte == ack2);
                        if (ack_now) begin
                            n_ack_seen = 1'b1;
                        end
                        n_prev_rx = i_in.rx_byte;
                        n_slot    = r_slot + 8'd1;
                        if ({1'b0, n_slot} >= total) begin
                            n_done   = 1'b1;
                            n_active = 1'b0;
                            if (!n_ack_seen) begin
                                n_status = shtfe_pkg::ST_NO_ACK;
                            end else if (!r_write_dir && !(n_checked && n_csum_ok)) begin
                                n_status = shtfe_pkg::ST_CSUM;
                            end else begin
                                n_status = shtfe_pkg::ST_OK;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload ram
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_payload_count[shtfe_pkg::STORE_AW-1:0]] <= i_in.payload_byte;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl            <= 1'b0;
            r_payload_count <= '0;
            r_slot          <= 8'h00;
            r_active        <= 1'b0;
            r_write_dir     <= 1'b0;
            r_addr          <= 8'h00;
            r_len           <= 8'h00;
            r_tx_csum       <= shtfe_pkg::CSUM_SEED;
            r_prev_rx       <= 8'h00;
            r_ack_seen      <= 1'b0;
            r_cap_cnt       <= 8'h00;
            r_rx_csum       <= shtfe_pkg::CSUM_SEED;
            r_csum_ok       <= 1'b0;
            r_checked       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dl <= i_cfg_wdata;
            end
            r_payload_count <= n_payload_count;
            r_slot          <= n_slot;
            r_active        <= n_active;
            r_write_dir     <= n_write_dir;
            r_addr          <= n_addr;
            r_len           <= n_len;
            r_tx_csum       <= n_tx_csum;
            r_prev_rx       <= n_prev_rx;
            r_ack_seen      <= n_ack_seen;
            r_cap_cnt       <= n_cap_cnt;
            r_rx_csum       <= n_rx_csum;
            r_csum_ok       <= n_csum_ok;
            r_checked       <= n_checked;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx     <= n_tx;
            r_rvalid <= n_rvalid;
            r_rbyte  <= n_rbyte;
            r_done   <= n_done;
            r_status <= n_status;
            r_busy   <= n_active;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.tx_byte    = r_tx;
    assign o_out.read_valid = r_rvalid;
    assign o_out.read_byte  = r_rbyte;
    assign o_out.done_res   = r_done;
    assign o_out.status     = r_status;
    assign o_out.busy_res   = r_busy;

endmodule

### tb/spi_hub_transfer_frame_engine_core_tb.sv
// self-checking testbench for the spi hub transfer frame engine core
`timescale 1ns / 100ps

module spi_hub_transfer_frame_engine_core_tb;

    localparam shtfe_pkg::t_cmd CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER  = 300;

    typedef enum int {REPLY_GOOD, REPLY_BAD_SUM, REPLY_NONE, REPLY_LATE, REPLY_EARLY} t_reply;

    typedef struct {
        shtfe_pkg::t_cmd cmd;
        logic            is_write;
        logic [7:0]      addr_byte;
        logic [7:0]      length;
        logic [7:0]      payload_byte;
        logic [7:0]      rx_byte;
    } t_hub_request;

    typedef struct {
        logic [7:0]         tx_byte;
        logic               read_valid;
        logic [7:0]         read_byte;
        logic               done_res;
        shtfe_pkg::t_status status;
        logic               busy_res;
    } t_hub_response;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    shtfe_in_if  in_if ();
    shtfe_out_if out_if ();

    spi_hub_transfer_frame_engine_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_hub_request  pending_requests [$];
    t_hub_response awaited_responses [$];
    int            queued_items  = 0;
    int            fail_count    = 0;
    int            results_seen  = 0;
    int            stuck_cycles  = 0;
    int            send_burst    = 0;
    int            send_gap      = 0;
    int            hold_left     = 0;
    bit            hold_done     = 0;
    int            stall_tick    = 0;
    int            stall_style   = 0;

    // engine state as the predictor sees it
    logic [7:0]  eng_store [shtfe_pkg::STORE_DEPTH];
    int          eng_fill          = 0;
    int          eng_slot          = 0;
    bit          eng_active        = 0;
    bit          eng_write         = 0;
    logic [7:0]  eng_addr          = 8'h00;
    logic [7:0]  eng_len           = 8'h00;
    logic [7:0]  eng_tx_sum        = shtfe_pkg::CSUM_SEED;
    logic [7:0]  eng_prev_rx       = 8'h00;
    bit          eng_acked         = 0;
    int          eng_captured      = 0;
    logic [7:0]  eng_rx_sum        = shtfe_pkg::CSUM_SEED;
    bit          eng_reply_ok      = 0;
    bit          eng_reply_checked = 0;
    bit          eng_download      = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic t_hub_response hub_engine_response(t_hub_request r);
        t_hub_response res;
        logic [7:0]    proto_rd, proto_wr, ack1, ack2, tx;
        int            lim, s, n, k;
        res = '{default: '0};
        tx = 8'h00;
        proto_rd = eng_download ? shtfe_pkg::DL_PROTO_RD : shtfe_pkg::REG_PROTO_RD;
        proto_wr = eng_download ? shtfe_pkg::DL_PROTO_WR : shtfe_pkg::REG_PROTO_WR;
        ack1 = eng_download ? shtfe_pkg::DL_ACK1 : shtfe_pkg::REG_ACK1;
        ack2 = eng_download ? shtfe_pkg::DL_ACK2 : shtfe_pkg::REG_ACK2;
        case (r.cmd)
            shtfe_pkg::CMD_LOAD: begin
                if (!eng_active && eng_fill < shtfe_pkg::STORE_DEPTH) begin
                    eng_store[eng_fill[shtfe_pkg::STORE_AW-1:0]] = r.payload_byte;
                    eng_fill++;
                end
            end
            shtfe_pkg::CMD_START: begin
                if (!eng_active) begin
                    lim = r.is_write ? shtfe_pkg::MAX_WRITE_LEN :
                          (eng_download ? shtfe_pkg::MAX_READ_LEN : shtfe_pkg::REG_READ_LEN);
                    eng_fill = 0;
                    if (int'(r.length) > lim) begin
                        res.done_res = 1'b1;
                        res.status = shtfe_pkg::ST_BAD_LEN;
                    end else begin
                        eng_active = 1;
                        eng_write = r.is_write;
                        eng_addr = r.addr_byte;
                        eng_len = r.length;
                        eng_slot = 0;
                        eng_tx_sum = shtfe_pkg::CSUM_SEED;
                        eng_prev_rx = 8'h00;
                        eng_acked = 0;
                        eng_captured = 0;
                        eng_rx_sum = shtfe_pkg::CSUM_SEED;
                        eng_reply_ok = 0;
                        eng_reply_checked = 0;
                    end
                end
            end
            shtfe_pkg::CMD_SLOT: begin
                if (eng_active) begin
                    s = eng_slot;
                    n = int'(eng_len);
                    k = s - shtfe_pkg::HDR_SLOTS;
                    if (s == 0) begin
                        tx = eng_write ? proto_wr : proto_rd;
                        eng_tx_sum ^= tx;
                    end else if (s == 1) begin
                        tx = eng_addr;
                        eng_tx_sum ^= tx;
                    end else if (s == 2) begin
                        tx = eng_len;
                        eng_tx_sum ^= tx;
                    end else if (s == 3) begin
                        tx = eng_tx_sum;
                        eng_tx_sum = shtfe_pkg::CSUM_SEED;
                    end else if (eng_write && s < shtfe_pkg::HDR_SLOTS + n) begin
                        tx = (k < eng_fill) ? eng_store[k[shtfe_pkg::STORE_AW-1:0]] : 8'h00;
                        eng_tx_sum ^= tx;
                    end else if (eng_write && s == shtfe_pkg::HDR_SLOTS + n) begin
                        tx = eng_tx_sum;
                    end
                    if (!eng_write && eng_acked) begin
                        if (eng_captured < n) begin
                            res.read_valid = 1'b1;
                            res.read_byte = r.rx_byte;
                            eng_rx_sum ^= r.rx_byte;
                            eng_captured++;
                        end else if (!eng_reply_checked) begin
                            eng_reply_checked = 1;
                            eng_reply_ok = (r.rx_byte == eng_rx_sum);
                        end
                    end
                    if (s >= (eng_write ? 1 : shtfe_pkg::HDR_SLOTS + 1) && eng_prev_rx == ack1 &&
                        r.rx_byte == ack2)
                        eng_acked = 1;
                    eng_prev_rx = r.rx_byte;
                    eng_slot = s + 1;
                    if (eng_slot >= n + shtfe_pkg::DUMMY_SLOTS) begin
                        res.done_res = 1'b1;
                        eng_active = 0;
                        if (!eng_acked)
                            res.status = shtfe_pkg::ST_NO_ACK;
                        else if (!eng_write && !(eng_reply_checked && eng_reply_ok))
                            res.status = shtfe_pkg::ST_CSUM;
                        else
                            res.status = shtfe_pkg::ST_OK;
                    end
                end
            end
            default: ;
        endcase
        res.tx_byte = tx;
        res.busy_res = eng_active;
        return res;
    endfunction

    function automatic t_hub_request rand_req(shtfe_pkg::t_cmd c);
        t_hub_request r;
        r.cmd = c;
        r.is_write = 1'($urandom_range(0, 1));
        r.addr_byte = 8'($urandom_range(0, 255));
        r.length = 8'($urandom_range(0, 255));
        r.payload_byte = 8'($urandom_range(0, 255));
        r.rx_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic send(t_hub_request r);
        pending_requests.push_back(r);
        queued_items++;
    endtask

    task automatic queue_start(bit wr, int addr, int len);
        t_hub_request r;
        r = rand_req(shtfe_pkg::CMD_START);
        r.is_write = wr;
        r.addr_byte = 8'(addr);
        r.length = 8'(len);
        send(r);
    endtask

    task automatic queue_transfer(bit wr, int len, t_reply reply, int loads);
        t_hub_request r;
        logic [7:0]   rx_seq [$];
        logic [7:0]   ack1, ack2, sum;
        int           total, p, i;
        ack1 = eng_download ? shtfe_pkg::DL_ACK1 : shtfe_pkg::REG_ACK1;
        ack2 = eng_download ? shtfe_pkg::DL_ACK2 : shtfe_pkg::REG_ACK2;
        for (i = 0; i < loads; i++)
            send(rand_req(shtfe_pkg::CMD_LOAD));
        queue_start(wr, $urandom_range(0, 255), len);
        total = len + shtfe_pkg::DUMMY_SLOTS;
        for (i = 0; i < total; i++)
            rx_seq.push_back(8'($urandom_range(0, 255)));
        if (reply != REPLY_NONE) begin
            if (wr)
                p = (reply == REPLY_EARLY) ? 0 : $urandom_range(0, total - 2);
            else if (reply == REPLY_EARLY)
                p = shtfe_pkg::HDR_SLOTS - 1;
            else if (reply == REPLY_LATE)
                p = $urandom_range(total - len - 2, total - 2);
            else
                p = $urandom_range(shtfe_pkg::HDR_SLOTS, total - len - 3);
            rx_seq[p] = ack1;
            rx_seq[p + 1] = ack2;
            if (!wr) begin
                sum = shtfe_pkg::CSUM_SEED;
                for (i = 0; i < len && p + 2 + i < total; i++)
                    sum ^= rx_seq[p + 2 + i];
                if (p + 2 + len < total)
                    rx_seq[p + 2 + len] = (reply == REPLY_BAD_SUM) ?
                                          sum ^ 8'($urandom_range(1, 255)) : sum;
            end
        end
        for (i = 0; i < total; i++) begin
            // requests that the busy engine must ignore
            if ($urandom_range(0, 99) < 3) begin
                case ($urandom_range(0, 2))
                    0: send(rand_req(shtfe_pkg::CMD_LOAD));
                    1: send(rand_req(shtfe_pkg::CMD_START));
                    default: send(rand_req(CMD_UNUSED));
                endcase
            end
            r = rand_req(shtfe_pkg::CMD_SLOT);
            r.rx_byte = rx_seq[i];
            send(r);
        end
    endtask

    task automatic queue_random_transfer();
        bit     wr;
        int     lim, len, pick, loads;
        t_reply reply;
        wr = 1'($urandom_range(0, 1));
        lim = wr ? shtfe_pkg::MAX_WRITE_LEN :
              (eng_download ? shtfe_pkg::MAX_READ_LEN : shtfe_pkg::REG_READ_LEN);
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
            send(rand_req($urandom_range(0, 1) ? shtfe_pkg::CMD_SLOT : CMD_UNUSED));
        if (pick < 6) begin
            queue_start(wr, $urandom_range(0, 255), $urandom_range(lim + 1, 255));
        end else begin
            if (pick < 70)
                len = $urandom_range(0, 6);
            else if (pick < 93)
                len = $urandom_range(7, 31);
            else
                len = lim;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                reply = REPLY_GOOD;
            else if (pick < 70)
                reply = REPLY_BAD_SUM;
            else if (pick < 80)
                reply = REPLY_NONE;
            else if (pick < 90)
                reply = REPLY_LATE;
            else
                reply = REPLY_EARLY;
            loads = wr ? $urandom_range(0, len + 2) : $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0)
                loads = shtfe_pkg::STORE_DEPTH + $urandom_range(0, 4);
            queue_transfer(wr, len, reply, loads);
        end
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || awaited_responses.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_download_mode(bit v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        eng_download = v;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_burst = 0;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                awaited_responses.push_back(hub_engine_response(pending_requests.pop_front()));
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0 || pending_requests.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    in_if.valid <= 1'b0;
                end else begin
                    in_if.valid <= 1'b1;
                    in_if.cmd <= pending_requests[0].cmd;
                    in_if.is_write <= pending_requests[0].is_write;
                    in_if.addr_byte <= pending_requests[0].addr_byte;
                    in_if.length <= pending_requests[0].length;
                    in_if.payload_byte <= pending_requests[0].payload_byte;
                    in_if.rx_byte <= pending_requests[0].rx_byte;
                    if (send_burst > 0) begin
                        send_burst--;
                    end else begin
                        send_burst = $urandom_range(0, 24);
                        send_gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_hub_response want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (awaited_responses.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = awaited_responses.pop_front();
                    check_field("tx_byte", want.tx_byte, out_if.tx_byte);
                    check_field("read_valid", 8'(want.read_valid), 8'(out_if.read_valid));
                    check_field("read_byte", want.read_byte, out_if.read_byte);
                    check_field("done_res", 8'(want.done_res), 8'(out_if.done_res));
                    check_field("status", 8'(want.status), 8'(out_if.status));
                    check_field("busy_res", 8'(want.busy_res), 8'(out_if.busy_res));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                // long hold so the engine backs up into the request side
                hold_done = 1;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                stall_tick++;
                if (stall_tick % 97 == 0)
                    stall_style = $urandom_range(0, 2);
                case (stall_style)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ($urandom_range(0, 9) >= 3);
                    default: out_if.ready <= (stall_tick % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int ph;
        int goal;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_if.valid = 1'b0;
        in_if.cmd = shtfe_pkg::CMD_LOAD;
        in_if.is_write = 1'b0;
        in_if.addr_byte = 8'h00;
        in_if.length = 8'h00;
        in_if.payload_byte = 8'h00;
        in_if.rx_byte = 8'h00;
        out_if.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register protocol: idle requests, rejected starts, edge transfers
        set_download_mode(1'b0);
        send('{CMD_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send('{shtfe_pkg::CMD_SLOT, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF});
        send('{shtfe_pkg::CMD_LOAD, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
        send('{shtfe_pkg::CMD_LOAD, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        queue_start(1'b1, 8'h00, shtfe_pkg::MAX_WRITE_LEN + 1);
        queue_start(1'b0, 8'h80, shtfe_pkg::REG_READ_LEN + 1);
        queue_start(1'b0, 8'hFF, 255);
        queue_transfer(1'b1, shtfe_pkg::MAX_WRITE_LEN, REPLY_GOOD, 2);
        queue_transfer(1'b0, 0, REPLY_GOOD, 0);
        wait_idle();

        // download protocol: wider read limit
        set_download_mode(1'b1);
        queue_start(1'b0, 8'h7F, shtfe_pkg::MAX_READ_LEN + 1);
        queue_start(1'b1, 8'h01, shtfe_pkg::MAX_WRITE_LEN + 1);
        queue_transfer(1'b0, shtfe_pkg::MAX_READ_LEN, REPLY_GOOD, 0);
        wait_idle();

        for (ph = 0; ph < 2; ph++) begin
            set_download_mode(ph[0]);
            goal = queued_items + 40;
            while (queued_items < goal)
                queue_random_transfer();
            wait_idle();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
hdl/shtfe_pkg.sv
hdl/shtfe_if.sv
hdl/spi_hub_transfer_frame_engine_core.sv
tb/spi_hub_transfer_frame_engine_core_tb.sv
